// ----- sv/tfpq_pkg.sv -----
package tfpq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int TIME_W        = 63;
    localparam int RCNT_W        = 5;

    localparam logic [1:0] ACT_ENQUEUE = 2'd0;
    localparam logic [1:0] ACT_TICK    = 2'd1;
    localparam logic [1:0] ACT_WIPE    = 2'd2;

    localparam logic [2:0] KIND_ACCEPTED   = 3'd0;
    localparam logic [2:0] KIND_REJECTED   = 3'd1;
    localparam logic [2:0] KIND_DROPPED    = 3'd2;
    localparam logic [2:0] KIND_PRESENTED  = 3'd3;
    localparam logic [2:0] KIND_WIPED      = 3'd4;
    localparam logic [2:0] KIND_NONE_READY = 3'd5;

    typedef struct packed {
        logic [1:0]        action;
        logic [TIME_W-1:0] time_ns;
        logic [15:0]       surface;
        logic [7:0]        queue_no;
        logic [13:0]       clip_w;
        logic [13:0]       clip_h;
    } item_t;

    typedef struct packed {
        logic [2:0]        kind;
        logic [15:0]       out_surface;
        logic [7:0]        out_queue;
        logic [13:0]       out_clip_w;
        logic [13:0]       out_clip_h;
        logic [TIME_W-1:0] done_time;
        logic [RCNT_W-1:0] removed_count;
        logic              last;
    } result_t;

    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_t;

endpackage

// ----- sv/tfpq_cmp.sv -----
module tfpq_cmp (
    input  logic [tfpq_pkg::TIME_W-1:0] a,
    input  logic [tfpq_pkg::TIME_W-1:0] b,
    output tfpq_pkg::cmp_t              res
);

    assign res.lt = (a < b);
    assign res.eq = (a == b);

endmodule

// ----- sv/timed_frame_present_queue_top.sv -----
// Channel   Direction  Handshake                     Payload
// command   in         start, busy                   item (tfpq_pkg::item_t)
// result    out        result_strobe (one cycle)     result (tfpq_pkg::result_t)
// config    in         cfg_we                        cfg_wdata (immediate mode)
//
// Every entry visited is first read from the store (one read and one write port), then used.
// Enqueue shifts each later entry up one place; wipe visits every stored entry.
// Tick scans the ready entries; if any are ready, it emits them and compacts the rest down.
// Reject and unused codes never raise busy.
// Reset clears occupancy and the last tick time; no clearing pass is needed.
// Results are not stalled: each is valid for exactly the cycle result_strobe is high.
module timed_frame_present_queue_top #(
    parameter int DEPTH = tfpq_pkg::DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  tfpq_pkg::item_t     item,
    output logic                result_strobe,
    output tfpq_pkg::result_t   result,
    input  logic                cfg_we,
    input  logic                cfg_wdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int TW = tfpq_pkg::TIME_W;
    localparam int RW = tfpq_pkg::RCNT_W;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_INS_RD  = 4'd1;
    localparam logic [3:0] S_INS_CMP = 4'd2;
    localparam logic [3:0] S_TK_RD   = 4'd3;
    localparam logic [3:0] S_TK_CMP  = 4'd4;
    localparam logic [3:0] S_TK_EVAL = 4'd5;
    localparam logic [3:0] S_EM_RD   = 4'd6;
    localparam logic [3:0] S_EM_OUT  = 4'd7;
    localparam logic [3:0] S_MV_RD   = 4'd8;
    localparam logic [3:0] S_MV_WR   = 4'd9;

    typedef struct packed {
        logic [TW-1:0] etime;
        logic [15:0]   surface;
        logic [7:0]    queue;
        logic [27:0]   clip;
    } entry_t;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    logic [3:0]          state_reg, state_next;
    logic [CW-1:0]       occ_reg, occ_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       dst_reg, dst_next;
    logic [CW-1:0]       ready_reg, ready_next;
    logic [TW-1:0]       last_tick_reg, last_tick_next;
    logic [TW-1:0]       t_reg, t_next;
    logic [TW-1:0]       newest_reg, newest_next;
    logic                imm_reg;
    tfpq_pkg::item_t     cmd_reg, cmd_next;
    tfpq_pkg::result_t   result_reg, result_next;
    logic                strobe_reg, strobe_next;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [AW-1:0]       mem_raddr;
    entry_t              mem_wdata;
    entry_t              new_entry;
    logic [TW-1:0]       cmp_a;
    logic [TW-1:0]       cmp_b;
    tfpq_pkg::cmp_t      cmp_res;
    logic [CW-1:0]       idx_dec;
    logic [CW-1:0]       idx_inc;

    tfpq_cmp u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .res (cmp_res)
    );

    assign busy          = (state_reg != S_IDLE);
    assign result        = result_reg;
    assign result_strobe = strobe_reg;

    assign idx_dec = idx_reg - CW'(1);
    assign idx_inc = idx_reg + CW'(1);

    assign new_entry.etime   = t_reg;
    assign new_entry.surface = cmd_reg.surface;
    assign new_entry.queue   = cmd_reg.queue_no;
    assign new_entry.clip    = {cmd_reg.clip_h, cmd_reg.clip_w};

    // Share one comparator: the time scan uses the transaction time, emission the newest time
    always_comb
    begin
        if (state_reg == S_EM_OUT)
        begin
            cmp_a = rd_data_reg.etime;
            cmp_b = newest_reg;
        end
        else
        begin
            cmp_a = t_reg;
            cmp_b = rd_data_reg.etime;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        idx_next       = idx_reg;
        dst_next       = dst_reg;
        ready_next     = ready_reg;
        last_tick_next = last_tick_reg;
        t_next         = t_reg;
        newest_next    = newest_reg;
        cmd_next       = cmd_reg;
        result_next    = '0;
        strobe_next    = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg[AW-1:0];
        mem_wdata      = new_entry;
        mem_raddr      = idx_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = item;
                    unique case (item.action)
                        tfpq_pkg::ACT_ENQUEUE:
                        begin
                            if (occ_reg == CW'(DEPTH))
                            begin
                                result_next.kind = tfpq_pkg::KIND_REJECTED;
                                result_next.last = 1'b1;
                                strobe_next      = 1'b1;
                            end
                            else
                            begin
                                t_next     = imm_reg ? last_tick_reg : item.time_ns;
                                idx_next   = occ_reg;
                                state_next = S_INS_RD;
                            end
                        end
                        tfpq_pkg::ACT_TICK:
                        begin
                            t_next         = item.time_ns;
                            last_tick_next = item.time_ns;
                            idx_next       = '0;
                            state_next     = S_TK_RD;
                        end
                        tfpq_pkg::ACT_WIPE:
                        begin
                            idx_next   = '0;
                            dst_next   = '0;
                            state_next = S_MV_RD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_INS_RD:
            begin
                if (idx_reg == '0)
                begin
                    mem_we           = 1'b1;
                    result_next.kind = tfpq_pkg::KIND_ACCEPTED;
                    result_next.last = 1'b1;
                    strobe_next      = 1'b1;
                    occ_next         = occ_reg + CW'(1);
                    state_next       = S_IDLE;
                end
                else
                begin
                    mem_raddr  = idx_dec[AW-1:0];
                    state_next = S_INS_CMP;
                end
            end

            S_INS_CMP:
            begin
                mem_we = 1'b1;
                if (cmp_res.lt)
                begin
                    // Later entry: shift it up one place
                    mem_wdata  = rd_data_reg;
                    idx_next   = idx_dec;
                    state_next = S_INS_RD;
                end
                else
                begin
                    result_next.kind = tfpq_pkg::KIND_ACCEPTED;
                    result_next.last = 1'b1;
                    strobe_next      = 1'b1;
                    occ_next         = occ_reg + CW'(1);
                    state_next       = S_IDLE;
                end
            end

            S_TK_RD:
            begin
                state_next = (idx_reg == occ_reg) ? S_TK_EVAL : S_TK_CMP;
            end

            S_TK_CMP:
            begin
                if (!cmp_res.lt)
                begin
                    newest_next = rd_data_reg.etime;
                    idx_next    = idx_inc;
                    state_next  = S_TK_RD;
                end
                else
                begin
                    state_next = S_TK_EVAL;
                end
            end

            S_TK_EVAL:
            begin
                if (idx_reg == '0)
                begin
                    result_next.kind = tfpq_pkg::KIND_NONE_READY;
                    result_next.last = 1'b1;
                    strobe_next      = 1'b1;
                    state_next       = S_IDLE;
                end
                else
                begin
                    ready_next = idx_reg;
                    idx_next   = '0;
                    state_next = S_EM_RD;
                end
            end

            S_EM_RD:
            begin
                state_next = S_EM_OUT;
            end

            S_EM_OUT:
            begin
                result_next.out_surface = rd_data_reg.surface;
                result_next.out_queue   = rd_data_reg.queue;
                result_next.done_time   = t_reg;
                result_next.last        = (idx_inc == ready_reg);
                strobe_next             = 1'b1;
                if (cmp_res.eq)
                begin
                    result_next.kind       = tfpq_pkg::KIND_PRESENTED;
                    result_next.out_clip_w = rd_data_reg.clip[13:0];
                    result_next.out_clip_h = rd_data_reg.clip[27:14];
                end
                else
                begin
                    result_next.kind = tfpq_pkg::KIND_DROPPED;
                end
                idx_next = idx_inc;
                if (idx_inc == ready_reg)
                begin
                    // Close the gap left by the presented and dropped entries
                    dst_next   = '0;
                    state_next = S_MV_RD;
                end
                else
                begin
                    state_next = S_EM_RD;
                end
            end

            S_MV_RD:
            begin
                if (idx_reg == occ_reg)
                begin
                    occ_next   = dst_reg;
                    state_next = S_IDLE;
                    if (cmd_reg.action == tfpq_pkg::ACT_WIPE)
                    begin
                        result_next.kind          = tfpq_pkg::KIND_WIPED;
                        result_next.removed_count = RW'(occ_reg - dst_reg);
                        result_next.last          = 1'b1;
                        strobe_next               = 1'b1;
                    end
                end
                else
                begin
                    state_next = S_MV_WR;
                end
            end

            S_MV_WR:
            begin
                if (!(cmd_reg.action == tfpq_pkg::ACT_WIPE &&
                      rd_data_reg.queue == cmd_reg.queue_no))
                begin
                    mem_we    = 1'b1;
                    mem_waddr = dst_reg[AW-1:0];
                    mem_wdata = rd_data_reg;
                    dst_next  = dst_reg + CW'(1);
                end
                idx_next   = idx_inc;
                state_next = S_MV_RD;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            last_tick_reg <= '0;
            imm_reg       <= 1'b0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            last_tick_reg <= last_tick_next;
            strobe_reg    <= strobe_next;
            if (cfg_we)
            begin
                imm_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        dst_reg    <= dst_next;
        ready_reg  <= ready_next;
        t_reg      <= t_next;
        newest_reg <= newest_next;
        cmd_reg    <= cmd_next;
        result_reg <= result_next;
    end

endmodule

// ----- sim/timed_frame_present_queue_top_tb.sv -----
`timescale 1ns / 1ps

module timed_frame_present_queue_top_tb;

    localparam int DEPTH       = tfpq_pkg::DEPTH_DEFAULT;
    localparam int TW          = tfpq_pkg::TIME_W;
    localparam int SETTLE      = 4 * DEPTH + 8;
    localparam int QUIET_LIMIT = 2000;
    localparam logic [TW-1:0] TIME_MAX = '1;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    tfpq_pkg::item_t   cmd = '0;
    logic              result_strobe;
    tfpq_pkg::result_t res;
    logic              cfg_we = 1'b0;
    logic              cfg_wdata = 1'b0;

    timed_frame_present_queue_top #(.DEPTH(DEPTH)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (cmd),
        .result_strobe (result_strobe),
        .result        (res),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always #6 clk = ~clk;

    // pending commands and the outcomes they are expected to produce
    tfpq_pkg::item_t   cmd_q[$];
    tfpq_pkg::result_t outcome_q[$];

    // shadow of the frame store
    logic [TW-1:0] slot_time[DEPTH];
    logic [15:0]   slot_surface[DEPTH];
    logic [7:0]    slot_queue[DEPTH];
    logic [13:0]   slot_cw[DEPTH];
    logic [13:0]   slot_ch[DEPTH];
    int            slot_count = 0;
    logic [TW-1:0] last_tick_ns = '0;
    logic          stamp_now = 1'b0;

    int   mismatch_count = 0;
    int   quiet_cycles = 0;
    logic cmd_taken = 1'b0;
    int   burst_left = 1;
    int   gap_left = 0;
    logic [TW-1:0] clock_ns;

    task automatic flag_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic drop_slot(input int idx);
        for (int j = idx; j + 1 < slot_count; j++) begin
            slot_time[j]    = slot_time[j + 1];
            slot_surface[j] = slot_surface[j + 1];
            slot_queue[j]   = slot_queue[j + 1];
            slot_cw[j]      = slot_cw[j + 1];
            slot_ch[j]      = slot_ch[j + 1];
        end
        slot_count--;
    endtask

    task automatic predict_outcome(input tfpq_pkg::item_t it);
        tfpq_pkg::result_t r;
        logic [TW-1:0]     t;
        logic [TW-1:0]     newest;
        int                pos;
        int                ready;
        int                removed;
        r = '0;
        r.last = 1'b1;
        t = it.time_ns;
        case (it.action)
            tfpq_pkg::ACT_ENQUEUE: begin
                if (slot_count >= DEPTH) begin
                    r.kind = tfpq_pkg::KIND_REJECTED;
                end else begin
                    if (stamp_now)
                        t = last_tick_ns;
                    pos = 0;
                    while (pos < slot_count && slot_time[pos] <= t)
                        pos++;
                    for (int j = slot_count; j > pos; j--) begin
                        slot_time[j]    = slot_time[j - 1];
                        slot_surface[j] = slot_surface[j - 1];
                        slot_queue[j]   = slot_queue[j - 1];
                        slot_cw[j]      = slot_cw[j - 1];
                        slot_ch[j]      = slot_ch[j - 1];
                    end
                    slot_time[pos]    = t;
                    slot_surface[pos] = it.surface;
                    slot_queue[pos]   = it.queue_no;
                    slot_cw[pos]      = it.clip_w;
                    slot_ch[pos]      = it.clip_h;
                    slot_count++;
                    r.kind = tfpq_pkg::KIND_ACCEPTED;
                end
                outcome_q.push_back(r);
            end
            tfpq_pkg::ACT_TICK: begin
                last_tick_ns = t;
                ready = 0;
                while (ready < slot_count && slot_time[ready] <= t)
                    ready++;
                if (ready == 0) begin
                    r.kind = tfpq_pkg::KIND_NONE_READY;
                    outcome_q.push_back(r);
                end else begin
                    newest = slot_time[ready - 1];
                    // drop everything older than the newest ready time, present the rest
                    while (slot_count > 0 && slot_time[0] <= newest) begin
                        r = '0;
                        r.out_surface = slot_surface[0];
                        r.out_queue   = slot_queue[0];
                        r.done_time   = t;
                        if (slot_time[0] < newest) begin
                            r.kind = tfpq_pkg::KIND_DROPPED;
                        end else begin
                            r.kind       = tfpq_pkg::KIND_PRESENTED;
                            r.out_clip_w = slot_cw[0];
                            r.out_clip_h = slot_ch[0];
                        end
                        r.last = (slot_count == 1) || (slot_time[1] > newest);
                        outcome_q.push_back(r);
                        drop_slot(0);
                    end
                end
            end
            tfpq_pkg::ACT_WIPE: begin
                pos = 0;
                removed = 0;
                while (pos < slot_count) begin
                    if (slot_queue[pos] == it.queue_no) begin
                        drop_slot(pos);
                        removed++;
                    end else begin
                        pos++;
                    end
                end
                r.kind = tfpq_pkg::KIND_WIPED;
                r.removed_count = removed[tfpq_pkg::RCNT_W-1:0];
                outcome_q.push_back(r);
            end
            default: ;
        endcase
    endtask

    task automatic cmp_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task automatic check_outcome(input tfpq_pkg::result_t got);
        tfpq_pkg::result_t want;
        if (outcome_q.size() == 0) begin
            flag_mismatch($sformatf("unexpected result kind %0d", got.kind));
        end else begin
            want = outcome_q.pop_front();
            cmp_field("kind", 64'(got.kind), 64'(want.kind));
            cmp_field("out_surface", 64'(got.out_surface), 64'(want.out_surface));
            cmp_field("out_queue", 64'(got.out_queue), 64'(want.out_queue));
            cmp_field("out_clip_w", 64'(got.out_clip_w), 64'(want.out_clip_w));
            cmp_field("out_clip_h", 64'(got.out_clip_h), 64'(want.out_clip_h));
            cmp_field("done_time", 64'(got.done_time), 64'(want.done_time));
            cmp_field("removed_count", 64'(got.removed_count), 64'(want.removed_count));
            cmp_field("last", 64'(got.last), 64'(want.last));
        end
    endtask

    // monitor: results first, they belong to an older transaction
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_we)
                stamp_now = cfg_wdata;
            if (result_strobe)
                check_outcome(res);
            if (start && !busy)
                predict_outcome(cmd);
            if (result_strobe || (start && !busy))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
                $display("timed_frame_present_queue_top_tb: FAIL");
                $finish;
            end
        end
        cmd_taken <= start && !busy;
    end

    // driver: bursts of commands separated by random gaps
    always @(negedge clk) begin
        if (rst_n && (!start || cmd_taken)) begin
            if (gap_left > 0) begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (cmd_q.size() > 0) begin
                cmd <= cmd_q.pop_front();
                start <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    function automatic tfpq_pkg::item_t make_item(input logic [1:0] act,
                                                  input logic [TW-1:0] t,
                                                  input logic [15:0] surf,
                                                  input logic [7:0] q,
                                                  input logic [13:0] cw,
                                                  input logic [13:0] ch);
        tfpq_pkg::item_t it;
        it.action   = act;
        it.time_ns  = t;
        it.surface  = surf;
        it.queue_no = q;
        it.clip_w   = cw;
        it.clip_h   = ch;
        return it;
    endfunction

    function automatic logic [TW-1:0] rand_time();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[TW-1:0];
    endfunction

    function automatic logic [TW-1:0] step_ns(input int unsigned lo, input int unsigned hi);
        return TW'(10 * $urandom_range(lo, hi));
    endfunction

    function automatic logic [15:0] rand_surface();
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [13:0] rand_clip();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return 14'($urandom_range(0, 16383));
        endcase
    endfunction

    function automatic logic [7:0] rand_queue();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, 3));
    endfunction

    task automatic push_enqueue(input logic [TW-1:0] t, input logic [7:0] q);
        cmd_q.push_back(make_item(tfpq_pkg::ACT_ENQUEUE, t, rand_surface(), q,
                                  rand_clip(), rand_clip()));
    endtask

    // one burst of enqueues, perhaps a wipe and an unused command, then one or two ticks
    task automatic add_round(inout int budget);
        int            n;
        logic [TW-1:0] t;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 19) : $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 15) == 0)
                t = rand_time();
            else
                t = clock_ns + step_ns(0, 6);
            push_enqueue(t, rand_queue());
        end
        budget -= n;
        if ($urandom_range(0, 4) == 0) begin
            cmd_q.push_back(make_item(tfpq_pkg::ACT_WIPE, rand_time(), rand_surface(),
                                      rand_queue(), rand_clip(), rand_clip()));
            budget--;
        end
        if ($urandom_range(0, 11) == 0)
            cmd_q.push_back(make_item(ACT_UNUSED, rand_time(), rand_surface(),
                                      8'($urandom_range(0, 255)), rand_clip(), rand_clip()));
        for (int k = ($urandom_range(0, 3) == 0) ? 2 : 1; k > 0; k--) begin
            case ($urandom_range(0, 15))
                0: t = TIME_MAX;
                1: t = rand_time();
                2: t = clock_ns - step_ns(1, 6);
                default: t = clock_ns + step_ns(0, 6);
            endcase
            cmd_q.push_back(make_item(tfpq_pkg::ACT_TICK, t, rand_surface(),
                                      8'($urandom_range(0, 255)), rand_clip(), rand_clip()));
            budget--;
            clock_ns += step_ns(0, 7);
        end
    endtask

    task automatic run_random(input int count);
        int budget;
        budget = count;
        clock_ns = rand_time() >> 2;
        while (budget > 0)
            add_round(budget);
    endtask

    task automatic write_mode(input logic v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // hold until every command is taken and every outcome has arrived
    task automatic wait_idle();
        while (cmd_q.size() != 0 || start || busy || outcome_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        write_mode(1'b0);

        // empty store, then equal times in arrival order, a drop and a backwards tick
        cmd_q.push_back(make_item(tfpq_pkg::ACT_TICK, 63'd1000, '0, '0, '0, '0));
        cmd_q.push_back(make_item(tfpq_pkg::ACT_WIPE, '0, '0, 8'd5, '0, '0));
        cmd_q.push_back(make_item(tfpq_pkg::ACT_ENQUEUE, 63'd100, '1, '1, '1, '1));
        cmd_q.push_back(make_item(tfpq_pkg::ACT_ENQUEUE, 63'd100, '0, '0, '0, '0));
        cmd_q.push_back(make_item(tfpq_pkg::ACT_ENQUEUE, 63'd50, 16'd1, 8'd1, 14'd7, 14'd9));
        cmd_q.push_back(make_item(tfpq_pkg::ACT_ENQUEUE, TIME_MAX, 16'h5a5a, 8'h80,
                                  14'h2aaa, 14'h1555));
        cmd_q.push_back(make_item(ACT_UNUSED, TIME_MAX, '1, '1, '1, '1));
        cmd_q.push_back(make_item(tfpq_pkg::ACT_TICK, 63'd10, '0, '0, '0, '0));
        cmd_q.push_back(make_item(tfpq_pkg::ACT_TICK, 63'd100, '0, '0, '0, '0));
        // fill the store in falling time order, overflow it, wipe, flush
        for (int i = 0; i < DEPTH - 1; i++)
            push_enqueue(TW'(DEPTH - 1 - i), (i % 2) ? 8'd3 : 8'd2);
        push_enqueue(63'd7, 8'd2);
        cmd_q.push_back(make_item(tfpq_pkg::ACT_WIPE, '0, '0, 8'd2, '0, '0));
        cmd_q.push_back(make_item(tfpq_pkg::ACT_TICK, TIME_MAX, '0, '0, '0, '0));
        wait_idle();

        write_mode(1'b1);
        run_random(140);
        wait_idle();
        write_mode(1'b0);
        run_random(140);
        wait_idle();
        write_mode(1'b1);
        run_random(140);
        wait_idle();

        if (mismatch_count == 0)
            $display("timed_frame_present_queue_top_tb: PASS");
        else
            $display("timed_frame_present_queue_top_tb: FAIL");
        $finish;
    end

endmodule
